>>> rtl/lcps_pkg.sv
package lcps_pkg;

  localparam int MAX_PEERS_DEF = 512;

  localparam int COUNT_W    = 16;
  localparam int TOTAL_W    = 32;
  localparam int LEN_W      = 24;
  localparam int SLOPE_W    = 16;
  localparam int ICPT_W     = 24;
  localparam int NPEER_W    = 10;
  localparam int PIDX_W     = 9;
  localparam int COSTI_W    = 18;
  localparam int COST_W     = 34;
  localparam int LOAD_W     = 52;
  localparam int PROD_W     = LEN_W + SLOPE_W;
  localparam int MUL_W      = COST_W + COUNT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PEERS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_SLOPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COST_INTERCEPT = 2'd2;

  localparam logic FUNC_ASSIGN  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [NPEER_W-1:0] ACTIVE_PEERS_RST   = 10'd1;
  localparam logic [SLOPE_W-1:0] COST_SLOPE_RST     = 16'd565;
  localparam logic [ICPT_W-1:0]  COST_INTERCEPT_RST = 24'd7869202;

  localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};
  localparam logic [LOAD_W-1:0]  LOAD_MAX  = {LOAD_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
  } peer_state_t;

  typedef struct packed {
    logic               shift;
    peer_state_t        tail;
  } ring_ctl_t;

  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  req_bytes;
    logic [PIDX_W-1:0] peer_index;
  } in_word_t;

  typedef struct packed {
    logic [PIDX_W-1:0]  chosen_peer;
    logic [COSTI_W-1:0] request_cost;
    logic [LOAD_W-1:0]  win_load;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COST,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD,
    ST_OUT
  } state_t;

endpackage

>>> rtl/least_cost_peer_selector_top.sv
// Least-cost peer selector.
// Input channel (in_valid/in_ready/in_data) takes one word per request: an
// assign picks the peer with the lowest projected load, a release hands a
// request back to the named peer. Each word yields one result word on the
// out_valid/out_ready/out_data channel.
// Per-peer state sits in a ring of MAX_PEERS cells that, while a rotation is
// under way, rotates one place a cycle past a single load unit (one multiplier,
// one add and compare). Assign: one rotation to scan, one to write back.
// Release: one rotation.
// One word is in flight at a time; in_ready is high only between words.
// The result sits in an output register; a stalled receiver holds it there
// and the next word is still accepted, but its result waits until the
// register is free.
// Config port (cfg_valid/cfg_index/cfg_data) is always ready; write it only
// while the block is idle.
// Synchronous reset clears all peer counts and totals and restores the
// register defaults.
module least_cost_peer_selector_top #(
  parameter int MAX_PEERS = lcps_pkg::MAX_PEERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lcps_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lcps_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0] cfg_data
);

  lcps_pkg::peer_state_t chain [MAX_PEERS];
  lcps_pkg::ring_ctl_t   ring_ctl;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_PEERS; gi++) begin : g_cell
      if (gi == MAX_PEERS - 1) begin : g_tail
        lcps_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (ring_ctl.shift),
          .d     (ring_ctl.tail),
          .q     (chain[gi])
        );
      end else begin : g_body
        lcps_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .shift (ring_ctl.shift),
          .d     (chain[gi+1]),
          .q     (chain[gi])
        );
      end
    end
  endgenerate

  lcps_ctrl #(
    .MAX_PEERS (MAX_PEERS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (chain[0]),
    .ring_ctl  (ring_ctl)
  );

`ifndef NO_ASSERTIONS
  // ring only moves while a word is being worked on
  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ring_ctl.shift |-> !in_ready)
    else $error("ring rotating while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !ring_ctl.shift))
    else $error("block not busy after accepting a word");

  a_ring_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ring_ctl.shift |=> $stable(chain[0]))
    else $error("head cell changed without a shift");
`endif

endmodule

>>> rtl/lcps_cell.sv
module lcps_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  lcps_pkg::peer_state_t d,
  output lcps_pkg::peer_state_t q
);

  lcps_pkg::peer_state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (shift) begin
      state_r <= d;
    end
  end

  assign q = state_r;

endmodule

>>> rtl/lcps_ctrl.sv
module lcps_ctrl #(
  parameter int MAX_PEERS = lcps_pkg::MAX_PEERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  lcps_pkg::in_word_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output lcps_pkg::out_word_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lcps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lcps_pkg::peer_state_t              head,
  output lcps_pkg::ring_ctl_t                ring_ctl
);

  localparam int IW   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CMPW = ((IW > lcps_pkg::NPEER_W) ? IW : lcps_pkg::NPEER_W) + 1;
  localparam logic [IW-1:0] STEP_LAST = IW'(MAX_PEERS - 1);

  lcps_pkg::state_t state_r, state_nxt;

  logic [lcps_pkg::NPEER_W-1:0] active_peers_r;
  logic [lcps_pkg::SLOPE_W-1:0] slope_r;
  logic [lcps_pkg::ICPT_W-1:0]  icpt_r;

  logic                         func_r;
  logic [lcps_pkg::LEN_W-1:0]   len_r;
  logic [lcps_pkg::PIDX_W-1:0]  peer_r;
  logic [lcps_pkg::PROD_W-1:0]  prod_r;
  logic [lcps_pkg::COST_W-1:0]  cost_r;
  logic [lcps_pkg::PROD_W:0]    cost_sum;
  logic [lcps_pkg::COSTI_W-1:0] ci;

  logic [IW-1:0] step_r;
  logic          step_last;
  logic          drain_r;

  logic                         p1_v_r, p2_v_r;
  logic [IW-1:0]                p1_idx_r, p2_idx_r;
  logic [lcps_pkg::COUNT_W:0]   p1_cnt_r;
  logic [lcps_pkg::TOTAL_W-1:0] p1_tot_r, p2_tot_r;
  logic [lcps_pkg::MUL_W-1:0]   p2_mul_r;
  logic [lcps_pkg::LOAD_W:0]    load_sum;
  logic [lcps_pkg::LOAD_W-1:0]  load;

  logic [lcps_pkg::LOAD_W-1:0]  best_load_r;
  logic [IW-1:0]                best_idx_r;
  logic                         found_r;

  logic                         out_valid_r;
  lcps_pkg::out_word_t          out_data_r;
  logic                         out_load;

  logic                         hit;
  logic [lcps_pkg::TOTAL_W:0]   tot_add;
  lcps_pkg::peer_state_t        upd;

  assign step_last = (step_r == STEP_LAST);
  assign ci        = cost_r[lcps_pkg::COST_W-1:16];
  assign cost_sum  = (lcps_pkg::PROD_W+1)'(prod_r) + (lcps_pkg::PROD_W+1)'(icpt_r);

  // load = total in Q.16 plus cost * (count + 1)
  assign load_sum = (lcps_pkg::LOAD_W+1)'({p2_tot_r, 16'h0000})
                  + (lcps_pkg::LOAD_W+1)'(p2_mul_r);
  assign load     = (load_sum > (lcps_pkg::LOAD_W+1)'(lcps_pkg::LOAD_MAX)) ?
                    lcps_pkg::LOAD_MAX : load_sum[lcps_pkg::LOAD_W-1:0];

  // write-back of the word leaving the head of the ring
  always_comb begin
    hit = 1'b0;
    if (func_r == lcps_pkg::FUNC_ASSIGN) begin
      hit = (step_r == best_idx_r);
    end else begin
      hit = (CMPW'(step_r) == CMPW'(peer_r));
    end
    tot_add = (lcps_pkg::TOTAL_W+1)'(head.total) + (lcps_pkg::TOTAL_W+1)'(ci);
    upd = head;
    if (func_r == lcps_pkg::FUNC_ASSIGN) begin
      if (head.count != lcps_pkg::COUNT_MAX) upd.count = head.count + 1'b1;
      upd.total = tot_add[lcps_pkg::TOTAL_W] ? lcps_pkg::TOTAL_MAX :
                  tot_add[lcps_pkg::TOTAL_W-1:0];
    end else begin
      if (head.count != '0) upd.count = head.count - 1'b1;
      upd.total = (head.total > lcps_pkg::TOTAL_W'(ci)) ?
                  head.total - lcps_pkg::TOTAL_W'(ci) : '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    ring_ctl.shift = 1'b0;
    ring_ctl.tail  = head;
    out_load       = 1'b0;
    case (state_r)
      lcps_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lcps_pkg::ST_MUL;
      end
      lcps_pkg::ST_MUL: begin
        state_nxt = lcps_pkg::ST_COST;
      end
      lcps_pkg::ST_COST: begin
        state_nxt = (func_r == lcps_pkg::FUNC_ASSIGN) ? lcps_pkg::ST_SCAN : lcps_pkg::ST_UPD;
      end
      lcps_pkg::ST_SCAN: begin
        ring_ctl.shift = 1'b1;
        if (step_last) state_nxt = lcps_pkg::ST_DRAIN;
      end
      lcps_pkg::ST_DRAIN: begin
        if (drain_r) state_nxt = lcps_pkg::ST_UPD;
      end
      lcps_pkg::ST_UPD: begin
        ring_ctl.shift = 1'b1;
        if (hit) ring_ctl.tail = upd;
        if (step_last) state_nxt = lcps_pkg::ST_OUT;
      end
      lcps_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = lcps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_peers_r <= lcps_pkg::ACTIVE_PEERS_RST;
      slope_r        <= lcps_pkg::COST_SLOPE_RST;
      icpt_r         <= lcps_pkg::COST_INTERCEPT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lcps_pkg::CFG_ACTIVE_PEERS:   active_peers_r <= cfg_data[lcps_pkg::NPEER_W-1:0];
        lcps_pkg::CFG_COST_SLOPE:     slope_r        <= cfg_data[lcps_pkg::SLOPE_W-1:0];
        lcps_pkg::CFG_COST_INTERCEPT: icpt_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      drain_r     <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == lcps_pkg::ST_IDLE && in_valid) begin
        func_r <= in_data.func;
        len_r  <= in_data.req_bytes;
        peer_r <= in_data.peer_index;
      end
      if (state_r == lcps_pkg::ST_MUL) begin
        prod_r <= lcps_pkg::PROD_W'(len_r) * lcps_pkg::PROD_W'(slope_r);
      end
      if (state_r == lcps_pkg::ST_COST) begin
        cost_r      <= (cost_sum > (lcps_pkg::PROD_W+1)'(lcps_pkg::COST_MAX)) ?
                       lcps_pkg::COST_MAX : cost_sum[lcps_pkg::COST_W-1:0];
        best_load_r <= lcps_pkg::LOAD_MAX;
        best_idx_r  <= '0;
        found_r     <= 1'b0;
        step_r      <= '0;
        drain_r     <= 1'b0;
      end
      if (ring_ctl.shift) begin
        step_r <= step_last ? '0 : step_r + 1'b1;
      end
      if (state_r == lcps_pkg::ST_DRAIN) drain_r <= 1'b1;

      // load pipeline: capture, multiply, compare
      p1_v_r   <= (state_r == lcps_pkg::ST_SCAN) && (CMPW'(step_r) < CMPW'(active_peers_r));
      p1_idx_r <= step_r;
      p1_cnt_r <= (lcps_pkg::COUNT_W+1)'(head.count) + 1'b1;
      p1_tot_r <= head.total;
      p2_v_r   <= p1_v_r;
      p2_idx_r <= p1_idx_r;
      p2_tot_r <= p1_tot_r;
      p2_mul_r <= lcps_pkg::MUL_W'(cost_r) * lcps_pkg::MUL_W'(p1_cnt_r);
      // strict compare in ascending order keeps the lowest index on a tie
      if (p2_v_r && (!found_r || load < best_load_r)) begin
        best_load_r <= load;
        best_idx_r  <= p2_idx_r;
        found_r     <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_data_r.request_cost <= ci;
        if (func_r == lcps_pkg::FUNC_ASSIGN) begin
          out_data_r.chosen_peer <= lcps_pkg::PIDX_W'(best_idx_r);
          out_data_r.win_load    <= best_load_r;
        end else begin
          out_data_r.chosen_peer <= peer_r;
          out_data_r.win_load    <= '0;
        end
      end
    end
  end

  assign in_ready  = (state_r == lcps_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
